@@ rtl/gossip_forward_limit_table_top_assert.svh @@
// Assertion macros shared by the forward limit table RTL.
`ifndef GOSSIP_FORWARD_LIMIT_TABLE_TOP_ASSERT_SVH
`define GOSSIP_FORWARD_LIMIT_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that an expression holds at every clock edge outside reset.
`define GFLT_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("%m: invariant violated");

// Checks that a condition in one cycle implies a consequence in the next.
`define GFLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define GFLT_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define GFLT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/gflt_pkg.sv @@
// Package with widths, reset values and shared types of the forward limit table.
`timescale 1ns / 1ps

package gflt_pkg;

    localparam int KEY_W           = 32;
    localparam int LIMIT_W         = 16;
    localparam int COUNT_W         = 16;
    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic [COUNT_W-1:0] COUNT_MAX         = {COUNT_W{1'b1}};
    localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT_RST = 16'd3;

    // Result of the parallel key compare.
    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] count;
    } t_lookup;

    // Update request back into the table for the current word.
    typedef struct packed {
        logic bump;    // increment the count of the matching entry
        logic insert;  // write the key into the next free entry
    } t_update;

endpackage

@@ rtl/gossip_forward_limit_table_top.sv @@
// Top level of the gossip forward limit table: input stage, limit decision and result stage.
`timescale 1ns / 1ps
`include "gossip_forward_limit_table_top_assert.svh"

// Channel   | Handshake          | Payload
// ----------+--------------------+------------------------------------------
// input     | start, busy        | i_message_key[31:0], i_stop_limit[15:0]
// result    | o_done (strobe)    | o_stop
// config    | i_cfg_we           | i_cfg_wdata[15:0] (default limit)
//
// One word is accepted in every cycle; busy stays low. Each word passes through
// the input register and then the result register, which drives its result.
// The table lookup, the limit compare and the table update of a word all
// happen in the cycle it sits in the input register, so the next word already
// sees the updated table.
// Reset (i_rst_n low at a clock edge) invalidates every entry at once and loads
// the default limit with 3. The receiver cannot stall; o_done is a one-cycle strobe.

module gossip_forward_limit_table_top #(
    parameter int TABLE_DEPTH = gflt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [gflt_pkg::KEY_W-1:0]     i_message_key,
    input  logic [gflt_pkg::LIMIT_W-1:0]   i_stop_limit,
    input  logic                           i_cfg_we,
    input  logic [gflt_pkg::LIMIT_W-1:0]   i_cfg_wdata,
    output logic                           o_done,
    output logic                           o_stop
);

    // Input stage registers.
    logic                         r_in_vld;
    logic [gflt_pkg::KEY_W-1:0]   r_in_key;
    logic [gflt_pkg::LIMIT_W-1:0] r_in_limit;

    // Configuration register.
    logic [gflt_pkg::LIMIT_W-1:0] r_default_limit;

    // Result stage registers.
    logic                         r_out_vld;
    logic                         r_out_stop;

    gflt_pkg::t_lookup            w_lookup;
    gflt_pkg::t_update            w_update;
    logic [gflt_pkg::LIMIT_W-1:0] w_limit;
    logic                         w_stop;
    logic                         w_accept;

    // The pipeline never holds off a word.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld        <= 1'b0;
            r_out_vld       <= 1'b0;
            r_default_limit <= gflt_pkg::DEFAULT_LIMIT_RST;
        end else begin
            r_in_vld  <= w_accept;
            r_out_vld <= r_in_vld;
            if (i_cfg_we) begin
                r_default_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_key   <= i_message_key;
            r_in_limit <= i_stop_limit;
        end
        r_out_stop <= w_stop;
    end

    // A zero limit in the word selects the programmed default.
    assign w_limit = (r_in_limit == '0) ? r_default_limit : r_in_limit;

    // A known key whose count has reached its limit is blocked and leaves the table alone.
    assign w_stop = w_lookup.hit && (w_lookup.count >= w_limit);

    // A known key below its limit counts one more pass; an unknown key is inserted.
    assign w_update.bump   = r_in_vld && w_lookup.hit && !w_stop;
    assign w_update.insert = r_in_vld && !w_lookup.hit;

    gflt_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (r_in_key),
        .o_lookup (w_lookup),
        .i_update (w_update)
    );

    assign o_done = r_out_vld;
    assign o_stop = r_out_stop;

    `GFLT_ASSERT_NEXT(a_word_gives_result, i_clk, i_rst_n, r_in_vld, o_done)
    `GFLT_ASSERT_NEXT(a_no_spurious_result, i_clk, i_rst_n, !r_in_vld, !o_done)
    `GFLT_ASSERT_NEXT(a_new_key_passes, i_clk, i_rst_n, r_in_vld && !w_lookup.hit, !o_stop)

endmodule

@@ rtl/gflt_table.sv @@
// Key table: flip-flop entries with parallel compare, fill-in-order insert and clear on full.
`timescale 1ns / 1ps
`include "gossip_forward_limit_table_top_assert.svh"

module gflt_table #(
    parameter int TABLE_DEPTH = gflt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [gflt_pkg::KEY_W-1:0]    i_key,
    output gflt_pkg::t_lookup             o_lookup,
    input  gflt_pkg::t_update             i_update
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int OCC_W = $clog2(TABLE_DEPTH + 1);

    logic [TABLE_DEPTH-1:0]       r_valid;
    logic [TABLE_DEPTH-1:0]       n_valid;
    logic [OCC_W-1:0]             r_occ;
    logic [OCC_W-1:0]             n_occ;
    logic [gflt_pkg::KEY_W-1:0]   r_key   [TABLE_DEPTH];
    logic [gflt_pkg::COUNT_W-1:0] r_count [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0]       w_hit_vec;
    logic [gflt_pkg::COUNT_W-1:0] w_hit_count;
    logic [OCC_W-1:0]             w_occ_inc;
    logic                         w_full;
    logic [IDX_W-1:0]             w_wr_idx;

    // Valid keys are unique, so at most one entry matches and an AND-OR mux suffices.
    always_comb begin
        w_hit_count = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_hit_vec[i] = r_valid[i] && (r_key[i] == i_key);
            w_hit_count  = w_hit_count | ({gflt_pkg::COUNT_W{w_hit_vec[i]}} & r_count[i]);
        end
    end

    assign o_lookup.hit   = |w_hit_vec;
    assign o_lookup.count = w_hit_count;

    assign w_occ_inc = r_occ + OCC_W'(1);
    assign w_full    = (w_occ_inc == OCC_W'(TABLE_DEPTH));
    assign w_wr_idx  = r_occ[IDX_W-1:0];

    always_comb begin
        n_valid = r_valid;
        n_occ   = r_occ;
        if (i_update.insert) begin
            if (w_full) begin
                n_valid = '0;
                n_occ   = '0;
            end else begin
                n_valid[w_wr_idx] = 1'b1;
                n_occ             = w_occ_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
        end else begin
            r_valid <= n_valid;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i_update.insert && (w_wr_idx == IDX_W'(i))) begin
                r_key[i]   <= i_key;
                r_count[i] <= gflt_pkg::COUNT_W'(1);
            end else if (i_update.bump && w_hit_vec[i] &&
                         (r_count[i] != gflt_pkg::COUNT_MAX)) begin
                r_count[i] <= r_count[i] + gflt_pkg::COUNT_W'(1);
            end
        end
    end

    `GFLT_ASSERT_ALWAYS(a_occ_matches_valid, i_clk, i_rst_n, $countones(r_valid) == r_occ)
    `GFLT_ASSERT_ALWAYS(a_single_match, i_clk, i_rst_n, $onehot0(w_hit_vec))
    `GFLT_ASSERT_ALWAYS(a_no_bump_and_insert, i_clk, i_rst_n, !(i_update.bump && i_update.insert))

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the gossip forward limit table top level.
`timescale 1ns / 1ps

// The testbench drives message words into the forward limit table and checks
// the stop flag of every result against its own model of the table.
//
// The initial block runs the test in phases. Each phase starts with the block
// idle. It then writes the default limit register and fills a queue of pending
// words. A clocked driver feeds those words to the block with random idle
// bursts. The driver runs the table model at the edge where each word is
// accepted, so the expected stop flags are queued in acceptance order.
// A clocked monitor pops one expectation for every o_done strobe and compares
// it with o_stop. A watchdog ends the run if nothing is accepted on either
// side for too long.
//
// Most random words use a small pool of recurring keys. This makes the counts
// climb to their limits and produces stop results. The rest use fresh random
// keys, so the table keeps filling up and clearing itself.

module tb;

    localparam int DEPTH          = gflt_pkg::TABLE_DEPTH_DEF;
    localparam int POOL_SIZE      = 6;
    localparam int PHASE_WORDS    = 235;
    localparam int NUM_PHASES     = 7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTS     = 40;

    typedef struct packed {
        logic [gflt_pkg::KEY_W-1:0]   key;
        logic [gflt_pkg::LIMIT_W-1:0] limit;
    } t_fwd_word;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [gflt_pkg::KEY_W-1:0]    i_message_key;
    logic [gflt_pkg::LIMIT_W-1:0]  i_stop_limit;
    logic                          i_cfg_we;
    logic [gflt_pkg::LIMIT_W-1:0]  i_cfg_wdata;
    logic                          o_done;
    logic                          o_stop;

    // Words waiting for the driver, and stop flags waiting for the monitor.
    t_fwd_word pending_words[$];
    logic      expected_stop[$];

    // Table model: valid bits, keys, pass counts, fill level and default limit.
    logic                         tbl_valid [DEPTH];
    logic [gflt_pkg::KEY_W-1:0]   tbl_key   [DEPTH];
    logic [gflt_pkg::COUNT_W-1:0] tbl_count [DEPTH];
    int                           tbl_fill;
    logic [gflt_pkg::LIMIT_W-1:0] fwd_default;

    int   err_count;
    int   gap_left;
    int   idle_pct;
    int   quiet_cycles;
    logic want_stop;

    gossip_forward_limit_table_top #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_message_key (i_message_key),
        .i_stop_limit  (i_stop_limit),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_done        (o_done),
        .o_stop        (o_stop)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTS) begin
            $display("MISMATCH at %0t ns: %s", $realtime, msg);
        end
        err_count++;
    endtask

    // Applies one accepted word to the table model and returns its stop flag.
    // A zero limit in the word selects the default limit register.
    function automatic logic predict_forward(input logic [gflt_pkg::KEY_W-1:0] key,
                                             input logic [gflt_pkg::LIMIT_W-1:0] limit);
        logic [gflt_pkg::LIMIT_W-1:0] eff_limit;
        int                           hit;
        logic                         stop_flag;
        eff_limit = (limit == '0) ? fwd_default : limit;
        hit = -1;
        stop_flag = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_key[i] == key) begin
                hit = i;
            end
        end
        if (hit >= 0 && tbl_count[hit] >= eff_limit) begin
            // The key has used up its passes, so the table stays as it is.
            stop_flag = 1'b1;
        end else begin
            if (hit >= 0) begin
                if (tbl_count[hit] != gflt_pkg::COUNT_MAX) begin
                    tbl_count[hit] = tbl_count[hit] + gflt_pkg::COUNT_W'(1);
                end
            end else if (tbl_fill < DEPTH) begin
                tbl_valid[tbl_fill] = 1'b1;
                tbl_key[tbl_fill]   = key;
                tbl_count[tbl_fill] = gflt_pkg::COUNT_W'(1);
                tbl_fill++;
            end
            // Filling the last entry clears the whole table in the same step.
            if (tbl_fill >= DEPTH) begin
                for (int i = 0; i < DEPTH; i++) begin
                    tbl_valid[i] = 1'b0;
                end
                tbl_fill = 0;
            end
        end
        return stop_flag;
    endfunction

    // Driver. A word counts as accepted at an edge where start is high and busy
    // is low. The model runs at that edge, using the values that were on the
    // ports before the edge. While busy holds a word off, the word stays on the
    // ports unchanged.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                expected_stop.insert(expected_stop.size(),
                                     predict_forward(i_message_key, i_stop_limit));
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
                // This starts an idle burst of random length, counting this cycle.
                start    <= 1'b0;
                gap_left <= $urandom_range(15);
            end else if (pending_words.size() != 0) begin
                start         <= 1'b1;
                i_message_key <= pending_words[0].key;
                i_stop_limit  <= pending_words[0].limit;
                void'(pending_words.pop_front());
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor. The receiver cannot stall, so every o_done strobe is one result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_stop.size() == 0) begin
                report_mismatch($sformatf("result with no word outstanding, stop=%b", o_stop));
            end else begin
                want_stop = expected_stop.pop_front();
                if (o_stop !== want_stop) begin
                    report_mismatch($sformatf("stop got %b, expected %b", o_stop, want_stop));
                end
            end
        end
    end

    // Watchdog. It counts cycles with no word accepted on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    task automatic push_word(input logic [gflt_pkg::KEY_W-1:0] key,
                             input logic [gflt_pkg::LIMIT_W-1:0] limit);
        t_fwd_word w;
        w.key   = key;
        w.limit = limit;
        pending_words.insert(pending_words.size(), w);
    endtask

    // Waits until every queued word has been sent and every result has arrived.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_words.size() != 0 || start || expected_stop.size() != 0);
    endtask

    // The block is idle whenever this is called, so the model takes the new
    // value right away.
    task automatic write_default_limit(input logic [gflt_pkg::LIMIT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        fwd_default = value;
    endtask

    initial begin
        logic [gflt_pkg::KEY_W-1:0]   key_pool [POOL_SIZE];
        logic [gflt_pkg::KEY_W-1:0]   key;
        logic [gflt_pkg::LIMIT_W-1:0] limit;
        logic [gflt_pkg::LIMIT_W-1:0] cfg_value;
        int                           pick;

        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_message_key <= '0;
        i_stop_limit  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        err_count    = 0;
        gap_left     = 0;
        idle_pct     = 0;
        quiet_cycles = 0;
        fwd_default  = gflt_pkg::DEFAULT_LIMIT_RST;
        tbl_fill     = 0;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_count[i] = '0;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words under the reset default limit of 3. Key zero passes
        // three times and then stops. The all-ones key and limit check the
        // extremes. Explicit limits no greater than the count stop at once.
        @(negedge i_clk);
        idle_pct = 20;
        repeat (4) push_word('0, '0);
        push_word('1, '1);
        push_word('1, 16'd1);
        push_word('1, 16'd2);
        push_word('1, 16'd2);
        push_word(32'hA5A5_A5A5, 16'd1);
        push_word(32'hA5A5_A5A5, 16'd1);
        push_word(32'hA5A5_A5A5, '0);
        push_word(32'h5A5A_5A5A, '1);
        push_word(32'h5A5A_5A5A, '0);
        wait_drained();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            repeat (3) @(posedge i_clk);
            case (phase)
                0: cfg_value = '0;
                1: cfg_value = '1;
                2: cfg_value = 16'd1;
                3: cfg_value = 16'd2;
                4: cfg_value = 16'($urandom_range(8, 2));
                5: cfg_value = 16'($urandom_range(65535, 1));
                default: cfg_value = gflt_pkg::DEFAULT_LIMIT_RST;
            endcase
            write_default_limit(cfg_value);

            @(negedge i_clk);
            case (phase)
                2, 6: idle_pct = 0;
                3: idle_pct = 40;
                default: idle_pct = 25;
            endcase

            if (phase == 0) begin
                // With a default limit of zero, a key already in the table always
                // stops on a word with a zero limit. A new key is still inserted and passes.
                push_word(32'h1234_5678, '0);
                push_word(32'h1234_5678, '0);
                push_word(32'h1234_5678, 16'd4);
                push_word(32'h1234_5678, '0);
            end

            for (int i = 0; i < POOL_SIZE; i++) begin
                key_pool[i] = $urandom;
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(99) < 5) begin
                    key_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
                end
                pick = $urandom_range(99);
                key  = (pick < 65) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
                pick = $urandom_range(99);
                if (pick < 45) begin
                    limit = '0;
                end else if (pick < 80) begin
                    limit = 16'($urandom_range(6, 1));
                end else begin
                    limit = 16'($urandom);
                end
                push_word(key, limit);
            end
            wait_drained();
        end

        // Any stray result shows up in the monitor during this window.
        repeat (8) @(posedge i_clk);
        if (expected_stop.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_stop.size()));
        end
        if (err_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
